/* sv/bhpe_pkg.sv */
`timescale 1ns / 1ps
// bhpe_pkg: shared types and constants of the bicubic Hermite patch evaluator.
// No dependencies.
package bhpe_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int DATA_FRAC_BITS  = 16;
   localparam int OUT_FRAC_BITS   = 16;

   localparam int COORD_W   = COORD_FRAC_BITS + 1;   // Q1.C, up to 1.0
   localparam int WORD_W    = 32;                    // one corner word
   localparam int CSR_W     = 2 * WORD_W;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_PAIRS = 8;
   localparam int BASIS_W   = COORD_FRAC_BITS + 5;   // |h| < 12 * 1.0
   localparam int PROD_W    = BASIS_W + WORD_W;
   localparam int ACC1_W    = PROD_W + 2;
   localparam int T_W       = ACC1_W - COORD_FRAC_BITS;
   localparam int PROD2_W   = T_W + BASIS_W;
   localparam int ACC2_W    = PROD2_W + 2;
   localparam int R_SHIFT   = COORD_FRAC_BITS + DATA_FRAC_BITS - OUT_FRAC_BITS;
   localparam int RES_W     = 48;
   localparam int PIPE_DEPTH = 7;

   // opcode bit positions
   localparam int OP_BIT_DX = 0;
   localparam int OP_BIT_DY = 1;

   typedef logic signed [BASIS_W-1:0] basis_type;
   typedef logic signed [WORD_W-1:0]  word_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic [1:0]         opcode;
   } req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] result_value;
      logic                    saturated;
   } rsp_type;

endpackage

/* sv/bhpe_basis.sv */
`timescale 1ns / 1ps
// bhpe_basis: three-stage Hermite basis generator for one coordinate.
// Depends on bhpe_pkg.
module bhpe_basis (
   input  logic                        clock,
   input  logic                        en,
   input  logic [bhpe_pkg::COORD_W-1:0] coord,
   input  logic                        deriv,
   output bhpe_pkg::basis_type          h_out [4]
);
   import bhpe_pkg::*;

   localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << COORD_FRAC_BITS;
   localparam logic [2*COORD_W:0] HALF = (2*COORD_W+1)'(1) << (COORD_FRAC_BITS - 1);
   localparam basis_type ONE_S = BASIS_W'(1) << COORD_FRAC_BITS;

   // stage 1
   logic [COORD_W-1:0]   x1_ff, x1_in;
   logic [2*COORD_W-1:0] sq_ff;
   logic                 d1_ff;
   // stage 2
   logic [COORD_W-1:0]   x2x_ff, x2_ff, x2_in;
   logic [2*COORD_W-1:0] cube_ff;
   logic                 d2_ff;
   logic [2*COORD_W:0]   sq_rnd, cube_rnd;
   // stage 3
   logic [COORD_W-1:0]   x3_in;
   basis_type            sx, s2, s3;
   basis_type            h_ff [4];
   basis_type            h_in [4];

   assign x1_in   = (coord > ONE) ? ONE : coord;
   assign sq_rnd  = {1'b0, sq_ff} + HALF;
   assign x2_in   = sq_rnd[COORD_FRAC_BITS +: COORD_W];
   assign cube_rnd = {1'b0, cube_ff} + HALF;
   assign x3_in   = cube_rnd[COORD_FRAC_BITS +: COORD_W];

   always_comb begin
      sx = $signed(BASIS_W'(x2x_ff));
      s2 = $signed(BASIS_W'(x2_ff));
      s3 = $signed(BASIS_W'(x3_in));
      if (d2_ff) begin
         h_in[0] = BASIS_W'(6 * s2 - 6 * sx);
         h_in[1] = BASIS_W'(6 * sx - 6 * s2);
         h_in[2] = BASIS_W'(ONE_S - 4 * sx + 3 * s2);
         h_in[3] = BASIS_W'(3 * s2 - 2 * sx);
      end else begin
         h_in[0] = BASIS_W'(ONE_S - 3 * s2 + 2 * s3);
         h_in[1] = BASIS_W'(3 * s2 - 2 * s3);
         h_in[2] = BASIS_W'(sx - 2 * s2 + s3);
         h_in[3] = BASIS_W'(s3 - s2);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= x1_in;
         sq_ff   <= x1_in * x1_in;
         d1_ff   <= deriv;
         x2x_ff  <= x1_ff;
         x2_ff   <= x2_in;
         cube_ff <= x2_in * x1_ff;
         d2_ff   <= d1_ff;
         for (int i = 0; i < 4; i++) begin
            h_ff[i] <= h_in[i];
         end
      end
   end

   assign h_out = h_ff;

endmodule

/* sv/bhpe_mac.sv */
`timescale 1ns / 1ps
// bhpe_mac: four-stage product Hx^T * G * Hy with rounding and 48-bit clip.
// Depends on bhpe_pkg.
module bhpe_mac (
   input  logic                 clock,
   input  logic                 en,
   input  bhpe_pkg::basis_type  hx [4],
   input  bhpe_pkg::basis_type  hy [4],
   input  bhpe_pkg::word_type   grid [4][4],
   output bhpe_pkg::rsp_type    rsp_out
);
   import bhpe_pkg::*;

   localparam logic signed [ACC1_W-1:0] HALF1 = ACC1_W'(1) << (COORD_FRAC_BITS - 1);
   localparam logic signed [ACC2_W-1:0] HALF2 = ACC2_W'(1) << (R_SHIFT - 1);
   localparam logic signed [ACC2_W-1:0] RMAX  = ACC2_W'((65'sd1 <<< (RES_W - 1)) - 1);
   localparam logic signed [ACC2_W-1:0] RMIN  = -(ACC2_W'(1) << (RES_W - 1));

   logic signed [PROD_W-1:0]  p_ff [4][4];
   basis_type                 hy4_ff [4];
   basis_type                 hy5_ff [4];
   logic signed [T_W-1:0]     t_ff [4];
   logic signed [T_W-1:0]     t_in [4];
   logic signed [PROD2_W-1:0] q_ff [4];
   logic signed [ACC1_W-1:0]  acc1 [4];
   logic signed [ACC2_W-1:0]  acc2, r_full;
   rsp_type                   rsp_ff, rsp_in;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc1[j] = HALF1;
         for (int i = 0; i < 4; i++) begin
            acc1[j] = acc1[j] + ACC1_W'(p_ff[i][j]);
         end
         t_in[j] = T_W'(acc1[j] >>> COORD_FRAC_BITS);
      end
   end

   always_comb begin
      acc2 = HALF2;
      for (int j = 0; j < 4; j++) begin
         acc2 = acc2 + ACC2_W'(q_ff[j]);
      end
      r_full = acc2 >>> R_SHIFT;
      priority if (r_full > RMAX) begin
         rsp_in.result_value = RMAX[RES_W-1:0];
         rsp_in.saturated    = 1'b1;
      end else if (r_full < RMIN) begin
         rsp_in.result_value = RMIN[RES_W-1:0];
         rsp_in.saturated    = 1'b1;
      end else begin
         rsp_in.result_value = r_full[RES_W-1:0];
         rsp_in.saturated    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               p_ff[i][j] <= PROD_W'(hx[i]) * PROD_W'(grid[i][j]);
            end
            hy4_ff[i] <= hy[i];
            hy5_ff[i] <= hy4_ff[i];
            t_ff[i]   <= t_in[i];
            q_ff[i]   <= PROD2_W'(t_ff[i]) * PROD2_W'(hy5_ff[i]);
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_out = rsp_ff;

endmodule

/* sv/bicubic_hermite_patch_eval.sv */
`timescale 1ns / 1ps
// bicubic_hermite_patch_eval: top level, corner registers, valid pipeline.
// Depends on bhpe_pkg, bhpe_basis, bhpe_mac.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | req_data  (point_x, point_y, opcode)
//   rsp     | out | rsp_valid/rsp_stall  | rsp_data  (result_value, saturated)
//   csr     | in  | csr_wr_en            | csr_index, csr_wdata
//
// The pipeline runs the basis stages (square, cube, basis adds), then the matrix
// product stages (16 products, column sums, 4 products, final sum and clip).
// One beat per cycle is taken while the result channel is not stalled.
// The whole pipeline advances on one enable: a stall on a valid result holds
// every stage, and req_stall is raised in the same cycle.
// Reset is synchronous; it clears the valid bits and the corner registers.
module bicubic_hermite_patch_eval (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bhpe_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bhpe_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [bhpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bhpe_pkg::CSR_W-1:0]      csr_wdata
);
   import bhpe_pkg::*;

   word_type  grid_ff [4][4];
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic      en;
   basis_type hx [4];
   basis_type hy [4];
   logic [1:0] row;
   logic [1:0] col;

   // the pipeline moves unless a finished result is held back
   assign en        = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   // pair k: row k/2, columns 2*(k%2) (low word) and the next (high word)
   assign row = csr_index[2:1];
   assign col = {csr_index[0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               grid_ff[i][j] <= '0;
            end
         end
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_PAIRS))) begin
            grid_ff[row][col]      <= csr_wdata[WORD_W-1:0];
            grid_ff[row][col + 2'd1] <= csr_wdata[CSR_W-1:WORD_W];
         end
      end
   end

   bhpe_basis u_basis_x (
      .clock (clock),
      .en    (en),
      .coord (req_data.point_x),
      .deriv (req_data.opcode[OP_BIT_DX]),
      .h_out (hx)
   );

   bhpe_basis u_basis_y (
      .clock (clock),
      .en    (en),
      .coord (req_data.point_y),
      .deriv (req_data.opcode[OP_BIT_DY]),
      .h_out (hy)
   );

   bhpe_mac u_mac (
      .clock   (clock),
      .en      (en),
      .hx      (hx),
      .hy      (hy),
      .grid    (grid_ff),
      .rsp_out (rsp_data)
   );

endmodule

/* sv/bhpe_checker.sv */
`timescale 1ns / 1ps
// bhpe_checker: port-level assertions for the patch evaluator, bound to top.
// Depends on bhpe_pkg and bicubic_hermite_patch_eval.
module bhpe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bhpe_pkg::rsp_type rsp_data
);
   import bhpe_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result beat changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.result_value == {1'b0, {(RES_W-1){1'b1}}}) ||
         (rsp_data.result_value == {1'b1, {(RES_W-1){1'b0}}}))
      else $error("saturated result not at a bound");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind bicubic_hermite_patch_eval bhpe_checker u_bhpe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
